### src/e2e6_pkg.sv
// Shared types, constants and the CRC byte update for the profile 6 protect/check block.
package e2e6_pkg;

  // CRC-16 CCITT-FALSE
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Header layout relative to the header offset
  localparam int unsigned HDR_CRC_HI = 0;
  localparam int unsigned HDR_CRC_LO = 1;
  localparam int unsigned HDR_LEN_HI = 2;
  localparam int unsigned HDR_LEN_LO = 3;
  localparam int unsigned HDR_CNT    = 4;
  localparam int unsigned HDR_BYTES  = 5;

  // Configuration register indexes
  localparam logic CFG_DATA_ID    = 1'b0;
  localparam logic CFG_HDR_OFFSET = 1'b1;

  // Action codes
  localparam logic ACT_PROTECT = 1'b0;
  localparam logic ACT_CHECK   = 1'b1;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  // Classified item handed from front to back
  typedef struct packed {
    logic [7:0]  ob;        // byte to pass on
    logic        crc_en;    // byte enters the CRC
    logic        last;      // final byte of the message
    logic        bad;       // message invalid (valid on last only)
    logic        chk;       // check mode and header length matched
    logic [15:0] seen_crc;  // CRC found in the header
  } item_t;

  // Feed one byte into the CRC, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### src/e2e6_front.sv
// Front part: tracks the byte position, substitutes header bytes and classifies each item.
module e2e6_front #(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          action_i,
  input  logic [7:0]    data_byte_i,
  input  logic [12:0]   frame_length_i,
  input  logic          bump_count_i,
  input  logic          last_byte_i,
  input  logic [11:0]   header_offset_i,
  output logic          item_valid_o,
  input  logic          item_ready_i,
  output e2e6_pkg::item_t item_o
);
  import e2e6_pkg::*;

  localparam int unsigned PW = $clog2(MAX_FRAME + 1);
  localparam int unsigned CW = ((PW > 13) ? PW : 13) + 1;

  logic [PW-1:0] pos_q, pos_d;
  logic [12:0]   len_q, len_d;
  logic          act_q, act_d;
  logic          inc_q, inc_d;
  logic [15:0]   seen_len_q, seen_len_d;
  logic [15:0]   seen_crc_q, seen_crc_d;

  logic          first, acc;
  logic [12:0]   len_w;
  logic          act_w, inc_w;
  logic [CW-1:0] pos_x, off_x, len_x;
  logic          at_crc_hi, at_crc_lo, at_len_hi, at_len_lo, at_cnt;
  logic [7:0]    ob;
  logic          bad;

  assign in_ready_o   = item_ready_i;
  assign item_valid_o = in_valid_i;
  assign acc          = in_valid_i && item_ready_i;

  // Sample the per-message fields at the first byte
  assign first = (pos_q == '0);
  assign len_w = first ? frame_length_i : len_q;
  assign act_w = first ? action_i       : act_q;
  assign inc_w = first ? bump_count_i   : inc_q;

  assign pos_x = CW'(pos_q);
  assign off_x = CW'(header_offset_i);
  assign len_x = CW'(len_w);

  // Locate the header bytes
  assign at_crc_hi = (pos_x == off_x + CW'(HDR_CRC_HI));
  assign at_crc_lo = (pos_x == off_x + CW'(HDR_CRC_LO));
  assign at_len_hi = (pos_x == off_x + CW'(HDR_LEN_HI));
  assign at_len_lo = (pos_x == off_x + CW'(HDR_LEN_LO));
  assign at_cnt    = (pos_x == off_x + CW'(HDR_CNT));

  // Capture the header fields as they pass
  always_comb begin
    seen_crc_d = seen_crc_q;
    seen_len_d = seen_len_q;
    priority if (at_crc_hi) begin
      seen_crc_d[15:8] = data_byte_i;
    end else if (at_crc_lo) begin
      seen_crc_d[7:0] = data_byte_i;
    end else if (at_len_hi) begin
      seen_len_d[15:8] = data_byte_i;
    end else if (at_len_lo) begin
      seen_len_d[7:0] = data_byte_i;
    end else begin
      seen_crc_d = seen_crc_q;
    end
  end

  // Substitute length and counter when protecting
  always_comb begin
    ob = data_byte_i;
    if (act_w == ACT_PROTECT) begin
      priority if (at_len_hi) begin
        ob = {3'b000, len_w[12:8]};
      end else if (at_len_lo) begin
        ob = len_w[7:0];
      end else if (at_cnt && inc_w) begin
        ob = data_byte_i + 8'd1;
      end else begin
        ob = data_byte_i;
      end
    end
  end

  // Validity of the message as seen at its last byte
  assign bad = (pos_x < CW'(HDR_BYTES - 1))
            || (pos_x >= CW'(MAX_FRAME))
            || (len_x < CW'(HDR_BYTES))
            || (len_x > pos_x + CW'(1))
            || (off_x + CW'(HDR_BYTES) > pos_x + CW'(1))
            || (off_x + CW'(HDR_LEN_HI) > len_x);

  always_comb begin
    item_o.ob       = ob;
    item_o.crc_en   = (pos_x < len_x) && !at_crc_hi && !at_crc_lo;
    item_o.last     = last_byte_i;
    item_o.bad      = bad;
    item_o.chk      = (act_w == ACT_CHECK) && (seen_len_d == 16'(len_w));
    item_o.seen_crc = seen_crc_d;
  end

  // Advance or clear the message state
  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    act_d = act_q;
    inc_d = inc_q;
    if (acc) begin
      if (last_byte_i) begin
        pos_d = '0;
        len_d = '0;
        act_d = 1'b0;
        inc_d = 1'b0;
      end else begin
        pos_d = (pos_q < PW'(MAX_FRAME)) ? pos_q + PW'(1) : PW'(MAX_FRAME);
        len_d = len_w;
        act_d = act_w;
        inc_d = inc_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      len_q      <= '0;
      act_q      <= 1'b0;
      inc_q      <= 1'b0;
      seen_len_q <= '0;
      seen_crc_q <= '0;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
      act_q <= act_d;
      inc_q <= inc_d;
      if (acc) begin
        seen_len_q <= last_byte_i ? 16'h0000 : seen_len_d;
        seen_crc_q <= last_byte_i ? 16'h0000 : seen_crc_d;
      end
    end
  end

endmodule

### src/e2e6_queue.sv
// Short queue of classified items between front and back.
module e2e6_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  e2e6_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output e2e6_pkg::item_t pop_item_o
);
  import e2e6_pkg::*;

  localparam int unsigned AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned NW = $clog2(QDEPTH + 1);

  item_t         mem_q [QDEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != NW'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(QDEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == AW'(QDEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + NW'(1);
      2'b01:   cnt_d = cnt_q - NW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the item payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

### src/e2e6_back.sv
// Back part: runs the CRC, folds in the data id, checks and registers the result item.
module e2e6_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  e2e6_pkg::item_t item_i,
  input  logic [15:0]     data_id_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [15:0]     crc_value_o,
  output logic            check_ok_o,
  output logic            status_o,
  output logic            is_last_o
);
  import e2e6_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic        vld_q;
  logic        take;
  logic [15:0] crc_upd, crc_fin;

  logic [7:0]  ob_q;
  logic [15:0] crcv_q;
  logic        ok_q, st_q, last_q;

  assign item_ready_o = !vld_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;

  // Update the running CRC, then fold in the data id for the last byte
  assign crc_upd = item_i.crc_en ? crc_feed(crc_q, item_i.ob) : crc_q;
  assign crc_fin = crc_feed(crc_feed(crc_upd, data_id_i[15:8]), data_id_i[7:0]);

  always_comb begin
    crc_d = crc_q;
    if (take) begin
      crc_d = item_i.last ? CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
      vld_q <= 1'b0;
    end else begin
      crc_q <= crc_d;
      if (take) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // Hold the result item until it is taken
  always_ff @(posedge clk_i) begin
    if (take) begin
      ob_q   <= item_i.ob;
      last_q <= item_i.last;
      st_q   <= item_i.last && item_i.bad;
      crcv_q <= (item_i.last && !item_i.bad) ? crc_fin : 16'h0000;
      ok_q   <= item_i.last && !item_i.bad && item_i.chk && (item_i.seen_crc == crc_fin);
    end
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = ob_q;
  assign crc_value_o = crcv_q;
  assign check_ok_o  = ok_q;
  assign status_o    = st_q;
  assign is_last_o   = last_q;

endmodule

### src/e2e_profile6_protect_check_top.sv
// Top level of the end-to-end profile 6 protect/check block.
// Streams a message one byte per item and applies the profile 6 header (CRC-16
// CCITT-FALSE, big-endian length, counter) found at header_offset. In protect
// mode the length bytes are replaced and the counter optionally incremented; in
// check mode the header CRC and length are compared. The finished CRC, check
// result and status come with the last byte's result. The block takes one item
// every cycle while its output is taken, a rate set by the byte-wide CRC update
// that the back part does for each item. The front part is combinational, so
// an accepted item's result passes through the two-entry queue and then the
// output register before it can be taken. A held output fills the output
// register and the queue, three items, before the input stalls. Write the
// configuration only while no item is in flight.
module e2e_profile6_protect_check_top #(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte[7:0], frame_length[20:8],
                                     // bump_count[21], zero[23:22]
  input  logic [0:0]  s_axis_tuser,  // action[0]
  input  logic        s_axis_tlast,  // last_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_byte[7:0], crc_value[23:8], check_ok[24],
                                     // status[25], zero[31:26]
  output logic        m_axis_tlast   // is_last
);
  import e2e6_pkg::*;

  logic [15:0] data_id_q;
  logic [11:0] hdr_off_q;

  logic        f_valid, f_ready, b_valid, b_ready;
  item_t       f_item, b_item;
  logic [7:0]  out_byte;
  logic [15:0] crc_value;
  logic        check_ok, status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_id_q <= '0;
      hdr_off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DATA_ID:    data_id_q <= cfg_data_i;
        CFG_HDR_OFFSET: hdr_off_q <= cfg_data_i[11:0];
        default:        data_id_q <= data_id_q;
      endcase
    end
  end

  e2e6_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .action_i        (s_axis_tuser[0]),
    .data_byte_i     (s_axis_tdata[7:0]),
    .frame_length_i  (s_axis_tdata[20:8]),
    .bump_count_i    (s_axis_tdata[21]),
    .last_byte_i     (s_axis_tlast),
    .header_offset_i (hdr_off_q),
    .item_valid_o    (f_valid),
    .item_ready_i    (f_ready),
    .item_o          (f_item)
  );

  e2e6_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  e2e6_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .data_id_i    (data_id_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .crc_value_o  (crc_value),
    .check_ok_o   (check_ok),
    .status_o     (status),
    .is_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b000000, status, check_ok, crc_value, out_byte};

`ifndef SYNTHESIS
  // An invalid message never reports a passing check
  a_ok_excl_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(check_ok && status))
    else $error("check_ok and status both set");

  // Summary fields appear only on the last result
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (crc_value == 16'h0000 && !check_ok && !status))
    else $error("summary field set on a non-last result");

  // An invalid message reports no CRC
  a_bad_no_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status) |-> (crc_value == 16'h0000))
    else $error("CRC reported for an invalid message");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for the end-to-end profile 6 protect/check block.
module tb_top;
  import e2e6_pkg::*;

  localparam int unsigned FRAME_CAP    = 4096;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          LONG_FRAME   = 300;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          LONG_HOLD    = 300;

  // One result item as the block should present it
  typedef struct {
    logic [7:0]  out_byte;
    logic [15:0] crc_value;
    logic        check_ok;
    logic        status;
    logic        is_last;
  } frame_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = 1'b0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // data_byte[7:0], frame_length[20:8],
                                    // bump_count[21], zero[23:22]
  logic [0:0]  s_axis_tuser  = '0;  // action[0]
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // out_byte[7:0], crc_value[23:8], check_ok[24],
                                    // status[25], zero[31:26]
  logic        m_axis_tlast;

  // Predictor copy of the configuration and the per-message state
  logic [15:0] cfg_id;
  logic [11:0] cur_offset;
  int          msg_pos;
  logic [15:0] run_crc;
  logic [12:0] hold_len;
  logic        hold_act;
  logic        hold_inc;
  logic [15:0] hdr_len;
  logic [15:0] hdr_crc;

  frame_result_t expected_q[$];
  logic [7:0]    msg_buf[$];
  logic [7:0]    echo_q[$];
  logic [15:0]   echo_crc;

  int fail_count  = 0;
  int items_sent  = 0;
  int quiet_count = 0;
  int stall_req   = 0;
  int sink_hold   = 0;
  bit idle_on     = 1'b1;

  e2e_profile6_protect_check_top #(
    .MAX_FRAME(FRAME_CAP)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // CCITT-FALSE update, one message bit at a time from the top
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] s;
    logic        fb;
    s = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = s[15] ^ d[k];
      s  = {s[14:0], 1'b0};
      if (fb) s = s ^ CRC_POLY;
    end
    return s;
  endfunction

  // Clear the per-message state, as after a last byte
  function automatic void clear_frame();
    msg_pos  = 0;
    run_crc  = CRC_INIT;
    hold_len = '0;
    hold_act = ACT_PROTECT;
    hold_inc = 1'b0;
    hdr_len  = '0;
    hdr_crc  = '0;
  endfunction

  // Advance the predicted state by one accepted item and return its result
  function automatic frame_result_t profile6_step(input logic act, input logic [7:0] b,
                                                  input logic [12:0] flen, input logic inc,
                                                  input logic last);
    frame_result_t r;
    int            pos;
    int            off;
    int            len;
    int            total;
    logic [7:0]    ob;
    logic [15:0]   crc;
    logic          bad;
    pos = msg_pos;
    off = int'(cur_offset);
    if (pos == 0) begin
      hold_act = act;
      hold_len = flen;
      hold_inc = inc;
    end
    len = int'(hold_len);
    ob  = b;
    // capture the header fields as they go by
    if (pos == off + HDR_CRC_HI) hdr_crc[15:8] = b;
    else if (pos == off + HDR_CRC_LO) hdr_crc[7:0] = b;
    else if (pos == off + HDR_LEN_HI) hdr_len[15:8] = b;
    else if (pos == off + HDR_LEN_LO) hdr_len[7:0] = b;
    // substitute length and counter when protecting
    if (hold_act == ACT_PROTECT) begin
      if (pos == off + HDR_LEN_HI) ob = {3'b000, hold_len[12:8]};
      else if (pos == off + HDR_LEN_LO) ob = hold_len[7:0];
      else if (pos == off + HDR_CNT && hold_inc) ob = b + 8'd1;
    end
    if (pos < len && pos != off + HDR_CRC_HI && pos != off + HDR_CRC_LO)
      run_crc = crc_byte(run_crc, ob);
    r.out_byte  = ob;
    r.crc_value = '0;
    r.check_ok  = 1'b0;
    r.status    = 1'b0;
    r.is_last   = last;
    if (last) begin
      total = pos + 1;
      bad = total < HDR_BYTES || pos >= FRAME_CAP || len < HDR_BYTES || len > total ||
            off + HDR_BYTES > total || off + 2 > len;
      if (bad) begin
        r.status = 1'b1;
      end else begin
        crc = crc_byte(crc_byte(run_crc, cfg_id[15:8]), cfg_id[7:0]);
        r.crc_value = crc;
        r.check_ok  = hold_act == ACT_CHECK && int'(hdr_len) == len && hdr_crc == crc;
      end
      clear_frame();
    end else begin
      msg_pos = (pos < FRAME_CAP) ? pos + 1 : FRAME_CAP;
    end
    return r;
  endfunction

  initial begin
    cfg_id     = '0;
    cur_offset = '0;
    echo_crc   = '0;
    clear_frame();
  end

  // Predict on each accepted item, then compare each accepted result
  always @(posedge clk_i) begin
    frame_result_t want;
    frame_result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (msg_pos == 0) echo_q.delete();
        want = profile6_step(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[20:8],
                             s_axis_tdata[21], s_axis_tlast);
        echo_q.push_back(want.out_byte);
        if (want.is_last) echo_crc = want.crc_value;
        expected_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_byte  = m_axis_tdata[7:0];
        got.crc_value = m_axis_tdata[23:8];
        got.check_ok  = m_axis_tdata[24];
        got.status    = m_axis_tdata[25];
        got.is_last   = m_axis_tlast;
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: out_byte %h", got.out_byte);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            fail_count++;
          end
          if (got.crc_value !== want.crc_value) begin
            $error("crc_value: expected %h, got %h", want.crc_value, got.crc_value);
            fail_count++;
          end
          if (got.check_ok !== want.check_ok) begin
            $error("check_ok: expected %b, got %b", want.check_ok, got.check_ok);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %b, got %b", want.status, got.status);
            fail_count++;
          end
          if (got.is_last !== want.is_last) begin
            $error("is_last: expected %b, got %b", want.is_last, got.is_last);
            fail_count++;
          end
        end
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive the receiver: random holds, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_req > 0) begin
        sink_hold = stall_req;
        stall_req = 0;
      end else if (sink_hold == 0 && idle_on) begin
        case ($urandom_range(0, 99)) inside
          [0:9]:   sink_hold = $urandom_range(1, 3);
          [10:11]: sink_hold = $urandom_range(8, 40);
          default: sink_hold = 0;
        endcase
      end
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and hold it until accepted; entered and left at a falling edge
  task automatic send_byte(input logic act, input logic [7:0] b, input logic [12:0] flen,
                           input logic inc, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, inc, flen, b};
    s_axis_tuser  <= act;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Send msg_buf as one message; fields sampled only at the first byte get noise later on
  task automatic send_message(input logic act, input logic [12:0] flen, input logic inc);
    int n;
    n = msg_buf.size();
    for (int i = 0; i < n; i++) begin
      if (i == 0)
        send_byte(act, msg_buf[i], flen, inc, n == 1);
      else
        send_byte(1'($urandom_range(0, 1)), msg_buf[i], 13'($urandom_range(0, 4096)),
                  1'($urandom_range(0, 1)), i == n - 1);
    end
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write both registers while the block is idle
  task automatic set_config(input logic [15:0] id, input logic [11:0] off);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DATA_ID;
    cfg_data_i  <= id;
    cfg_id       = id;
    @(negedge clk_i);
    cfg_index_i <= CFG_HDR_OFFSET;
    cfg_data_i  <= {4'b0000, off};
    cur_offset   = off;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic fill_random(input int n);
    msg_buf.delete();
    repeat (n) msg_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic fill_const(input int n, input logic [7:0] v);
    msg_buf.delete();
    repeat (n) msg_buf.push_back(v);
  endtask

  // Protect msg_buf, insert the finished CRC, then send the result back in check mode
  task automatic protect_then_check(input logic [12:0] flen, input logic inc,
                                    input logic corrupt);
    int         idx;
    int         off;
    logic [7:0] mask;
    send_message(ACT_PROTECT, flen, inc);
    wait_drain();
    off     = int'(cur_offset);
    msg_buf = echo_q;
    if (msg_buf.size() > off + HDR_CRC_LO) begin
      msg_buf[off + HDR_CRC_HI] = echo_crc[15:8];
      msg_buf[off + HDR_CRC_LO] = echo_crc[7:0];
    end
    if (corrupt && msg_buf.size() > 0) begin
      idx          = $urandom_range(0, msg_buf.size() - 1);
      mask         = 8'(1 << $urandom_range(0, 7));
      msg_buf[idx] = msg_buf[idx] ^ mask;
    end
    send_message(ACT_CHECK, flen, 1'b0);
  endtask

  // Reset register values; counter wrap from FF with increment, then a matching check
  task automatic test_reset_defaults();
    fill_const(5, 8'hFF);
    protect_then_check(13'd5, 1'b1, 1'b0);
  endtask

  // Each way a message can be flagged invalid but a frame longer than MAX_FRAME bytes
  task automatic test_invalid_messages();
    set_config(16'h1234, 12'd0);
    fill_random(1);
    send_message(ACT_PROTECT, 13'd5, 1'b0);
    fill_random(5);
    send_message(ACT_CHECK, 13'd3, 1'b1);
    fill_const(5, 8'h00);
    send_message(ACT_PROTECT, 13'd4096, 1'b1);
    set_config(16'h1234, 12'd1);
    fill_random(5);
    send_message(ACT_PROTECT, 13'd5, 1'b0);
    set_config(16'hA5C3, 12'd4);
    fill_random(9);
    send_message(ACT_CHECK, 13'd5, 1'b0);
  endtask

  // Long frame with the header in its last five bytes, no idling
  task automatic test_long_frame();
    set_config(16'hFFFF, 12'(LONG_FRAME - HDR_BYTES));
    idle_on = 1'b0;
    fill_random(LONG_FRAME);
    protect_then_check(13'(LONG_FRAME), 1'b1, 1'b0);
    idle_on = 1'b1;
  endtask

  // Hold the receiver off while the sender keeps offering items
  task automatic test_backpressure();
    set_config(16'h5AA5, 12'd3);
    idle_on   = 1'b0;
    stall_req = LONG_HOLD;
    fill_random(40);
    send_message(ACT_PROTECT, 13'd36, 1'b1);
    idle_on = 1'b1;
  endtask

  // Mostly well-formed protect/check pairs under changing settings, plus noise
  task automatic test_random_traffic();
    int         start;
    int         msgs;
    int         r;
    int         off;
    int         total;
    int         lo;
    logic [15:0] id;
    logic [12:0] flen;
    start = items_sent;
    msgs  = 0;
    off   = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (msgs % 6 == 0) begin
        r = $urandom_range(0, 99);
        if (r < 15) id = 16'h0000;
        else if (r < 30) id = 16'hFFFF;
        else id = 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 70) off = $urandom_range(0, 12);
        else if (r < 92) off = $urandom_range(13, 60);
        else off = $urandom_range(61, 250);
        set_config(id, 12'(off));
        idle_on = ($urandom_range(0, 3) != 0);
      end
      msgs++;
      total = off + HDR_BYTES + $urandom_range(0, 24);
      lo    = (off + 2 > HDR_BYTES) ? off + 2 : HDR_BYTES;
      flen  = 13'($urandom_range(lo, total));
      r     = $urandom_range(0, 99);
      fill_random(total);
      if (r < 45) begin
        protect_then_check(flen, 1'($urandom_range(0, 1)), 1'b0);
      end else if (r < 60) begin
        protect_then_check(flen, 1'($urandom_range(0, 1)), 1'b1);
      end else if (r < 80) begin
        send_message(1'($urandom_range(0, 1)), flen, 1'($urandom_range(0, 1)));
      end else begin
        // broken sizes and lengths
        fill_random($urandom_range(1, off + 10));
        if ($urandom_range(0, 1))
          flen = 13'($urandom_range(0, 4096));
        else
          flen = 13'($urandom_range(0, msg_buf.size() + 2));
        send_message(1'($urandom_range(0, 1)), flen, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_invalid_messages();
    test_backpressure();
    test_long_frame();
    test_random_traffic();
    wait_drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
src/e2e6_pkg.sv
src/e2e6_front.sv
src/e2e6_queue.sv
src/e2e6_back.sv
src/e2e_profile6_protect_check_top.sv
sim/tb_top.sv
